// ----- hw/rtl/hid_keyboard_report_tracker_defines.svh -----
// Assertion macros shared by the keyboard report tracker RTL.
`ifndef HID_KEYBOARD_REPORT_TRACKER_DEFINES_SVH
`define HID_KEYBOARD_REPORT_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define HKRT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hkrt assertion failed");
`define HKRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hkrt assertion failed");
`else
`define HKRT_ASSERT_IMP(label, ante, cons)
`define HKRT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hw/rtl/hkrt_pkg.sv -----
// Types and constants for the keyboard report tracker.
`default_nettype none

package hkrt_pkg;

    localparam int KEY_SLOTS_DEFAULT = 6;
    localparam int REPORT_KEYS       = 6;

    localparam logic [7:0] CODE_NONE = 8'd0;
    localparam logic [7:0] MOD_FIRST = 8'd224;
    localparam logic [7:0] MOD_LAST  = 8'd231;

    // APB register map: one 32-bit register per word
    localparam int         APB_ADDR_W        = 3;
    localparam logic       CFG_REPORT_ENABLE = 1'b0;
    localparam logic       REPORT_ENABLE_RST = 1'b1;

    typedef struct packed {
        logic [7:0] key_code;
        logic       pressed;
    } hkrt_in_t;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } hkrt_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hkrt_slot_update.sv -----
// Key slot update: drop matches in the occupied prefix, close up, append on press.
`default_nettype none

module hkrt_slot_update #(
    parameter int KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEFAULT
) (
    input  hkrt_pkg::hkrt_in_t         evt,
    input  logic [KEY_SLOTS-1:0][7:0]  held,
    output logic [KEY_SLOTS-1:0][7:0]  held_next
);
    import hkrt_pkg::*;

    localparam int CW = $clog2(KEY_SLOTS + 1);
    localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic [KEY_SLOTS-1:0]         before_ok;   // every slot below s is occupied
    logic [KEY_SLOTS-1:0]         occupied;    // slot s lies in the occupied prefix
    logic [KEY_SLOTS-1:0]         drop;
    logic [KEY_SLOTS-1:0][CW-1:0] pos;
    logic [CW-1:0]                first_empty;
    logic [CW-1:0]                drop_total;
    logic [CW-1:0]                fill;
    logic [KEY_SLOTS-1:0][7:0]    packed_keys;

    always_comb begin
        for (int s = 0; s < KEY_SLOTS; s++) begin
            before_ok[s] = 1'b1;
            for (int j = 0; j < s; j++) begin
                before_ok[s] = before_ok[s] & (held[j] != CODE_NONE);
            end
            occupied[s] = before_ok[s] & (held[s] != CODE_NONE);
            drop[s]     = before_ok[s] & (held[s] == evt.key_code);
        end
    end

    // destination of each kept entry: its index less the drops below it
    always_comb begin
        for (int s = 0; s < KEY_SLOTS; s++) begin
            pos[s] = CW'(s) - CW'($countones(drop & KEY_SLOTS'((32'd1 << s) - 32'd1)));
        end
        first_empty = CW'($countones(occupied));
        drop_total  = CW'($countones(drop));
        fill        = first_empty - drop_total;
    end

    always_comb begin
        for (int d = 0; d < KEY_SLOTS; d++) begin
            packed_keys[d] = CODE_NONE;
            for (int s = d; s < KEY_SLOTS; s++) begin
                if (!drop[s] && (pos[s] == CW'(d))) begin
                    packed_keys[d] = held[s];
                end
            end
        end
        held_next = packed_keys;
        if (evt.pressed && (evt.key_code != CODE_NONE) && (fill < CW'(KEY_SLOTS))) begin
            held_next[fill[IW-1:0]] = evt.key_code;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hid_keyboard_report_tracker.sv -----
// Keyboard boot report tracker: top level with input stage, state and result register.
`default_nettype none

// Keeps a boot keyboard report: a modifier byte and KEY_SLOTS key slots, all
// zero after reset. A transaction on the s_ channel is registered, applied to
// the report once the input register can advance and, while report_enable is
// set, the updated report is loaded into the m_ result register. The rate is
// one event per cycle while the m_ side takes results (a held result stalls
// s_ready), set by the single-pass slot compare and compaction between the
// input register and the report state. Events with key code 0 leave the
// state alone and return nothing. report_enable sits at APB byte address 0
// (bit 0, reset 1); pready is always high.
module hid_keyboard_report_tracker #(
    parameter int KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  hkrt_pkg::hkrt_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output hkrt_pkg::hkrt_out_t               m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hkrt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import hkrt_pkg::*;

    `include "hid_keyboard_report_tracker_defines.svh"

    logic                      in_valid_reg;
    hkrt_in_t                  in_data_reg;
    logic [KEY_SLOTS-1:0][7:0] held_reg;
    logic [KEY_SLOTS-1:0][7:0] held_next;
    logic [7:0]                modifier_reg;
    logic [7:0]                modifier_next;
    logic                      report_enable_reg;
    logic                      m_valid_reg;
    hkrt_out_t                 m_data_reg;
    hkrt_out_t                 m_data_next;
    logic [REPORT_KEYS-1:0][7:0] report_keys;

    logic       code_valid;
    logic       emit;
    logic       advance;
    logic       is_mod;
    logic [7:0] mod_offset;
    logic [7:0] mod_mask;
    logic       cfg_hit;

    assign code_valid = in_data_reg.key_code != CODE_NONE;
    assign emit       = code_valid && report_enable_reg;
    // an event that yields no result retires without waiting on m_ready
    assign advance    = in_valid_reg && (!emit || !m_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    hkrt_slot_update #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_slot_update (
        .evt       (in_data_reg),
        .held      (held_reg),
        .held_next (held_next)
    );

    always_comb begin
        is_mod     = (in_data_reg.key_code >= MOD_FIRST) && (in_data_reg.key_code <= MOD_LAST);
        mod_offset = in_data_reg.key_code - MOD_FIRST;
        mod_mask   = 8'd1 << mod_offset[2:0];
        modifier_next = modifier_reg;
        if (is_mod) begin
            if (in_data_reg.pressed) begin
                modifier_next = modifier_reg | mod_mask;
            end else begin
                modifier_next = modifier_reg & ~mod_mask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= '0;
            modifier_reg <= 8'd0;
        end else if (advance && code_valid) begin
            held_reg     <= held_next;
            modifier_reg <= modifier_next;
        end
    end

    // slots past KEY_SLOTS report as empty
    for (genvar k = 0; k < REPORT_KEYS; k++) begin : g_report
        if (k < KEY_SLOTS) begin : g_slot
            assign report_keys[k] = held_next[k];
        end else begin : g_pad
            assign report_keys[k] = CODE_NONE;
        end
    end

    always_comb begin
        m_data_next.modifier_bits = modifier_next;
        m_data_next.key_slot_0    = report_keys[0];
        m_data_next.key_slot_1    = report_keys[1];
        m_data_next.key_slot_2    = report_keys[2];
        m_data_next.key_slot_3    = report_keys[3];
        m_data_next.key_slot_4    = report_keys[4];
        m_data_next.key_slot_5    = report_keys[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_hit = paddr[APB_ADDR_W-1:2] == CFG_REPORT_ENABLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            report_enable_reg <= REPORT_ENABLE_RST;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            report_enable_reg <= pwdata[0];
        end
    end

    assign prdata = cfg_hit ? {31'd0, report_enable_reg} : 32'd0;

    `HKRT_ASSERT_IMP(a_stall_cause, !s_ready, in_valid_reg && m_valid_reg && !m_ready)
    `HKRT_ASSERT_NEXT(a_zero_code_keeps_state, advance && !code_valid,
        $stable(held_reg) && $stable(modifier_reg))
    `HKRT_ASSERT_NEXT(a_emit_loads_result, advance && emit, m_valid_reg)

endmodule

`default_nettype wire

// ----- verif/hkrt_report_checker.sv -----
// Scoreboard for the keyboard report tracker: predicts each report and compares it.
`timescale 1ns / 1ps

module hkrt_report_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  hkrt_pkg::hkrt_in_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  hkrt_pkg::hkrt_out_t             m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hkrt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    output int                              mismatch_count,
    output int                              outstanding
);
    import hkrt_pkg::*;

    localparam int SLOTS = KEY_SLOTS_DEFAULT;
    localparam logic [APB_ADDR_W-1:0] ENABLE_ADDR = {CFG_REPORT_ENABLE, 2'b00};

    logic [7:0] modifier_state;
    logic [7:0] held_keys [SLOTS];
    logic       report_on;
    hkrt_out_t  expected_reports [$];
    int         errors = 0;
    string      field_names [7] = '{"modifier_bits", "key_slot_0", "key_slot_1",
                                    "key_slot_2", "key_slot_3", "key_slot_4",
                                    "key_slot_5"};

    // Apply one key event to the predicted report state.
    task automatic advance_report(input hkrt_in_t ev, output bit emits,
                                  output hkrt_out_t rpt);
        logic [7:0] next_keys [SLOTS];
        int         dst;
        int         fill;
        bit         before_gap;
        emits = 1'b0;
        rpt = '0;
        if (ev.key_code == CODE_NONE) return;
        if (ev.key_code >= MOD_FIRST && ev.key_code <= MOD_LAST)
            modifier_state[3'(ev.key_code - MOD_FIRST)] = ev.pressed;
        // drop copies ahead of the first empty slot and close up the rest
        dst = 0;
        fill = SLOTS;
        before_gap = 1'b1;
        for (int src = 0; src < SLOTS; src++) begin
            if (before_gap && held_keys[src] == CODE_NONE) begin
                before_gap = 1'b0;
                fill = dst;
            end
            if (!(before_gap && held_keys[src] == ev.key_code)) begin
                next_keys[dst] = held_keys[src];
                dst++;
            end
        end
        if (before_gap) fill = dst;
        for (int k = dst; k < SLOTS; k++) next_keys[k] = CODE_NONE;
        if (ev.pressed && fill < SLOTS) next_keys[fill] = ev.key_code;
        held_keys = next_keys;
        emits = report_on;
        rpt.modifier_bits = modifier_state;
        rpt.key_slot_0 = held_keys[0];
        rpt.key_slot_1 = held_keys[1];
        rpt.key_slot_2 = held_keys[2];
        rpt.key_slot_3 = held_keys[3];
        rpt.key_slot_4 = held_keys[4];
        rpt.key_slot_5 = held_keys[5];
    endtask

    always @(posedge aclk) begin : monitor
        hkrt_out_t want;
        hkrt_out_t got;
        bit        emits;
        if (!aresetn) begin
            modifier_state = '0;
            for (int k = 0; k < SLOTS; k++) held_keys[k] = CODE_NONE;
            report_on = REPORT_ENABLE_RST;
            expected_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ENABLE_ADDR)
                report_on = pwdata[0];
            if (s_valid && s_ready) begin
                advance_report(s_data, emits, want);
                if (emits) expected_reports.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_reports.size() == 0) begin
                    $display("%0t: report with none expected: expected none, actual %h",
                             $time, got);
                    errors++;
                end else begin
                    want = expected_reports.pop_front();
                    for (int k = 0; k < 7; k++) begin
                        if (want[55 - 8*k -: 8] !== got[55 - 8*k -: 8]) begin
                            $display("%0t: %s mismatch: expected %h, actual %h", $time,
                                     field_names[k], want[55 - 8*k -: 8],
                                     got[55 - 8*k -: 8]);
                            errors++;
                        end
                    end
                end
            end
        end
        mismatch_count <= errors;
        outstanding <= expected_reports.size();
    end

endmodule

// ----- verif/hid_keyboard_report_tracker_test.sv -----
// Testbench top for the keyboard report tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module hid_keyboard_report_tracker_test;
    import hkrt_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ENABLE_ADDR = {CFG_REPORT_ENABLE, 2'b00};
    localparam logic PRESS   = 1'b1;
    localparam logic RELEASE = 1'b0;
    localparam int   PHASES  = 10;
    localparam int   PHASE_EVENTS = 110;
    localparam int   LONG_STALL = 200;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    hkrt_in_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    hkrt_out_t             m_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    int                    mismatch_count;
    int                    outstanding;

    int sender_max_gap = 3;
    int rx_max_gap = 3;
    bit long_stall_req = 1'b0;

    always #6 aclk = ~aclk;

    hid_keyboard_report_tracker dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hkrt_report_checker scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    task automatic send_key(input logic [7:0] code, input logic pressed);
        int gap;
        gap = $urandom_range(0, sender_max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{key_code: code, pressed: pressed};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait until every expected report is out, then idle so that code-0 events retire too.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Result side: per-transaction random hold-off, or one long stall on request.
    initial begin : receiver
        int gap;
        forever begin
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                gap = LONG_STALL;
            end else begin
                gap = $urandom_range(0, rx_max_gap);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int         sent;
        int         pick;
        logic [7:0] code;
        logic       pressed;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(ENABLE_ADDR, 32'd1);

        // fill all six slots, overflow, repeat press, modifiers, code zero, extremes
        send_key(8'd4, PRESS);
        send_key(8'd5, PRESS);
        send_key(8'd6, PRESS);
        send_key(8'd7, PRESS);
        send_key(8'd8, PRESS);
        send_key(8'd9, PRESS);
        send_key(8'd10, PRESS);
        send_key(MOD_FIRST, PRESS);
        send_key(8'd5, PRESS);
        send_key(8'd4, RELEASE);
        send_key(MOD_FIRST, PRESS);
        send_key(MOD_LAST, PRESS);
        send_key(MOD_FIRST, RELEASE);
        send_key(CODE_NONE, PRESS);
        send_key(CODE_NONE, RELEASE);
        send_key(8'd10, RELEASE);
        send_key(8'd255, PRESS);
        send_key(8'd255, RELEASE);
        send_key(8'd1, PRESS);
        send_key(8'd200, RELEASE);
        send_key(MOD_LAST, RELEASE);
        send_key(8'd5, RELEASE);
        send_key(8'd6, RELEASE);
        send_key(8'd1, RELEASE);
        send_key(8'd128, PRESS);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            write_reg(ENABLE_ADDR, (phase % 3 == 2) ? 32'd0 : 32'hFFFF_FFFF);
            // some phases run back to back with no idle cycles on either side
            sender_max_gap = (phase % 4 == 3) ? 0 : 3;
            rx_max_gap = (phase % 4 == 3) ? 0 : 3;
            if (phase == 1) long_stall_req = 1'b1;
            sent = 0;
            while (sent < PHASE_EVENTS) begin
                pick = $urandom_range(0, 99);
                pressed = $urandom_range(0, 99) < 55;
                if (pick < 65)
                    code = 8'd4 + 8'($urandom_range(0, 9));
                else if (pick < 80)
                    code = MOD_FIRST + 8'($urandom_range(0, 7));
                else if (pick < 95)
                    code = 8'($urandom_range(1, 255));
                else
                    code = CODE_NONE;
                send_key(code, pressed);
                if (code != CODE_NONE) sent++;
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("PASS hid_keyboard_report_tracker");
        end else begin
            $display("FAIL hid_keyboard_report_tracker");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAIL hid_keyboard_report_tracker");
        $finish;
    end

endmodule
